// ----- sv/crfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package crfr_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned ElapsedW  = 13;
  localparam int unsigned IndexW    = 9;

  localparam logic [7:0]          BroadcastAddr  = 8'd255;
  localparam logic [ElapsedW-1:0] ElapsedMax     = 13'd8191;
  localparam logic [15:0]         CrcInit        = 16'hFFFF;
  localparam logic [15:0]         CrcPoly        = 16'h1021;
  localparam logic [7:0]          BaseTimeoutRst = 8'd25;
  localparam logic [3:0]          ByteTimeRst    = 4'd2;
  localparam logic [7:0]          MasterAddrRst  = 8'd0;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_TIMEOUT = 2'd0,
    CFG_PER_BYTE     = 2'd1,
    CFG_MASTER_ADDR  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ADDR = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CRCH = 3'd4,
    PH_CRCL = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_WAIT    = 3'd0,
    ST_STORED  = 3'd1,
    ST_OK      = 3'd2,
    ST_BAD     = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_IDLE    = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [7:0] tx_address;
    logic [7:0] tx_length;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        stored_byte;
    logic [IndexW-1:0] stored_index;
  } result_t;

  // crc-16/ccitt, msb first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/crc_framed_reply_receiver_unit.sv -----
// reply receiver for the master side of a serial polling protocol
// input channel (in_valid_i / in_ready_o): one beat is a command, 0 start after
//   transmit (tx_address_i, tx_length_i), 1 received byte (rx_byte_i), 2 a 1 ms tick
// output channel (out_valid_o / out_ready_i): exactly one result beat per input
//   beat, in order: status_o, and stored_byte_o / stored_index_o for header and data
// config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at the clock edge,
//   0 base timeout, 1 byte time, 2 master address; write only while the block is idle
// latency: a result is valid 1 cycle after its input beat is accepted, so it can
//   leave at the second edge (input register, then the single-pass decode/crc step
//   into the result register)
// throughput: one beat per cycle; the per-byte crc (8 bit steps) and the timeout
//   product sit between the input and result registers
// stall: while out_ready_i is low the result is held, one more beat is taken into
//   the input register, then in_ready_o drops until the result drains
// reset: both registers empty, phase idle, config back to 25 ms base timeout,
//   2 ms byte time and master address 0
`timescale 1ns / 1ps
`default_nettype none

module crc_framed_reply_receiver_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic [7:0]                    tx_address_i,
  input  wire logic [7:0]                    tx_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [2:0]                         status_o,
  output logic [7:0]                         stored_byte_o,
  output logic [crfr_pkg::IndexW-1:0]        stored_index_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [crfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [crfr_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import crfr_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  result_t core_res;
  result_t out_res;

  assign in_item = '{cmd: cmd_i, rx_byte: rx_byte_i, tx_address: tx_address_i,
                     tx_length: tx_length_i};

  // input register
  crfr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // receive state, config registers and the single-pass step
  crfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (item),
    .result_o    (core_res)
  );

  // result register; take also advances the receive state
  crfr_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .take_o       (take),
    .result_i     (core_res),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (out_res)
  );

  assign status_o       = out_res.status;
  assign stored_byte_o  = out_res.stored_byte;
  assign stored_index_o = out_res.stored_index;

  // input side only backs up when a result is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stuck result");

  // only stored beats carry byte and index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_STORED) |-> (stored_byte_o == 8'd0 && stored_index_o == '0))
    else $error("byte or index on a non-stored result");

  // buffer index never passes 257, one past the last data slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_STORED) |-> (stored_index_o <= IndexW'(257)))
    else $error("stored index out of range");

  // every taken item produces a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("taken item produced no result");

endmodule

`default_nettype wire

// ----- sv/crfr_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crfr_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire crfr_pkg::item_t in_item_i,
  input  wire logic           take_i,
  output logic                item_valid_o,
  output crfr_pkg::item_t     item_o
);
  import crfr_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;

  // free when empty or the held beat moves on this cycle
  assign in_ready_o = !vld_q || take_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ----- sv/crfr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crfr_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [crfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [crfr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                       take_i,
  input  wire crfr_pkg::item_t            item_i,
  output crfr_pkg::result_t               result_o
);
  import crfr_pkg::*;

  logic [7:0]          base_q;
  logic [3:0]          per_byte_q;
  logic [7:0]          master_q;

  phase_e              phase_q, phase_d;
  logic [15:0]         crc_q, crc_d;
  logic [7:0]          crc_hi_q, crc_hi_d;
  logic [7:0]          raddr_q, raddr_d;
  logic [7:0]          rlen_q, rlen_d;
  logic [7:0]          dcnt_q, dcnt_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [ElapsedW-1:0] limit_q, limit_d;

  logic [15:0]         crc_next;
  logic [ElapsedW-1:0] init_limit;
  logic [ElapsedW-1:0] elapsed_inc;
  logic [7:0]          dcnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BaseTimeoutRst;
      per_byte_q  <= ByteTimeRst;
      master_q    <= MasterAddrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_TIMEOUT: base_q      <= cfg_wdata_i;
        CFG_PER_BYTE:     per_byte_q  <= cfg_wdata_i[3:0];
        CFG_MASTER_ADDR:  master_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign crc_next    = crc_byte(crc_q, item_i.rx_byte);
  assign init_limit  = (ElapsedW'(item_i.tx_length) + ElapsedW'(4)) * ElapsedW'(per_byte_q)
                       + ElapsedW'(base_q);
  assign elapsed_inc = (elapsed_q < ElapsedMax) ? elapsed_q + 1'b1 : elapsed_q;
  assign dcnt_inc    = dcnt_q + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    crc_d     = crc_q;
    crc_hi_d  = crc_hi_q;
    raddr_d   = raddr_q;
    rlen_d    = rlen_q;
    dcnt_d    = dcnt_q;
    elapsed_d = elapsed_q;
    limit_d   = limit_q;
    result_o  = '{status: ST_WAIT, stored_byte: 8'd0, stored_index: '0};

    if (cmd_e'(item_i.cmd) == CMD_START) begin
      if (item_i.tx_address == BroadcastAddr) begin
        phase_d         = PH_IDLE;
        result_o.status = ST_OK;
      end else begin
        phase_d   = PH_ADDR;
        crc_d     = CrcInit;
        dcnt_d    = 8'd0;
        elapsed_d = '0;
        limit_d   = init_limit;
      end
    end else if (phase_q == PH_IDLE) begin
      result_o.status = ST_IDLE;
    end else begin
      case (cmd_e'(item_i.cmd))
        CMD_BYTE: begin
          elapsed_d = '0;
          case (phase_q)
            PH_ADDR: begin
              raddr_d  = item_i.rx_byte;
              crc_d    = crc_next;
              limit_d  = ElapsedW'(base_q);
              result_o = '{status: ST_STORED, stored_byte: item_i.rx_byte,
                           stored_index: '0};
              phase_d  = PH_LEN;
            end
            PH_LEN: begin
              rlen_d   = item_i.rx_byte;
              dcnt_d   = 8'd0;
              crc_d    = crc_next;
              result_o = '{status: ST_STORED, stored_byte: item_i.rx_byte,
                           stored_index: IndexW'(1)};
              phase_d  = (item_i.rx_byte == 8'd0) ? PH_CRCH : PH_DATA;
            end
            PH_DATA: begin
              crc_d    = crc_next;
              result_o = '{status: ST_STORED, stored_byte: item_i.rx_byte,
                           stored_index: IndexW'(dcnt_q) + IndexW'(2)};
              dcnt_d   = dcnt_inc;
              if (dcnt_inc >= rlen_q) begin
                phase_d = PH_CRCH;
              end
            end
            PH_CRCH: begin
              crc_hi_d = item_i.rx_byte;
              phase_d  = PH_CRCL;
            end
            default: begin
              result_o.status = (({crc_hi_q, item_i.rx_byte} == crc_q) && (raddr_q == master_q))
                                ? ST_OK : ST_BAD;
              phase_d = PH_IDLE;
            end
          endcase
        end
        CMD_TICK: begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= limit_q) begin
            result_o.status = ST_TIMEOUT;
            phase_d         = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      crc_q     <= CrcInit;
      crc_hi_q  <= 8'd0;
      raddr_q   <= 8'd0;
      rlen_q    <= 8'd0;
      dcnt_q    <= 8'd0;
      elapsed_q <= '0;
      limit_q   <= '0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      crc_q     <= crc_d;
      crc_hi_q  <= crc_hi_d;
      raddr_q   <= raddr_d;
      rlen_q    <= rlen_d;
      dcnt_q    <= dcnt_d;
      elapsed_q <= elapsed_d;
      limit_q   <= limit_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/crfr_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crfr_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_valid_i,
  output logic                   take_o,
  input  wire crfr_pkg::result_t result_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output crfr_pkg::result_t      result_o
);
  import crfr_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  // result register free when empty or being drained this cycle
  assign take_o = item_valid_i && (!vld_q || out_ready_i);
  assign vld_d  = take_o ? 1'b1 : (out_ready_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

// ----- tb/crc_framed_reply_receiver_unit_tb.sv -----
`timescale 1ns / 1ps

module crc_framed_reply_receiver_unit_tb;
  import crfr_pkg::*;

  // predicted receiver state, expected result beats, mismatch count
  class reply_scoreboard;
    logic [7:0]  base_timeout;
    logic [3:0]  per_byte;
    logic [7:0]  master_addr;
    phase_e      phase;
    logic [15:0] crc;
    logic [7:0]  crc_hi;
    logic [7:0]  reply_addr;
    logic [7:0]  reply_len;
    logic [7:0]  data_count;
    logic [12:0] elapsed;
    logic [12:0] limit;
    result_t     pending[$];
    int          mismatches;

    function new();
      base_timeout = BaseTimeoutRst;
      per_byte     = ByteTimeRst;
      master_addr  = MasterAddrRst;
      phase        = PH_IDLE;
      crc          = CrcInit;
      crc_hi       = '0;
      reply_addr   = '0;
      reply_len    = '0;
      data_count   = '0;
      elapsed      = '0;
      limit        = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] v);
      case (idx)
        CFG_BASE_TIMEOUT: base_timeout = v;
        CFG_PER_BYTE:     per_byte = v[3:0];
        CFG_MASTER_ADDR:  master_addr = v;
        default: ;
      endcase
    endfunction

    // bit-serial crc-16/ccitt, msb first
    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = c << 1;
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    function status_e note_beat(item_t it);
      result_t     r;
      status_e     st;
      logic [31:0] t;
      logic [15:0] got;
      r  = '0;
      st = ST_WAIT;
      if (it.cmd == CMD_START) begin
        if (it.tx_address == BroadcastAddr) begin
          phase = PH_IDLE;
          st    = ST_OK;
        end else begin
          phase      = PH_ADDR;
          crc        = CrcInit;
          data_count = '0;
          elapsed    = '0;
          t          = (32'(it.tx_length) + 32'd4) * 32'(per_byte) + 32'(base_timeout);
          limit      = t[12:0];
        end
      end else if (phase == PH_IDLE) begin
        st = ST_IDLE;
      end else if (it.cmd == CMD_BYTE) begin
        elapsed = '0;
        case (phase)
          PH_ADDR: begin
            reply_addr     = it.rx_byte;
            crc            = crc_next(crc, it.rx_byte);
            limit          = 13'(base_timeout);
            st             = ST_STORED;
            r.stored_byte  = it.rx_byte;
            r.stored_index = '0;
            phase          = PH_LEN;
          end
          PH_LEN: begin
            reply_len      = it.rx_byte;
            data_count     = '0;
            crc            = crc_next(crc, it.rx_byte);
            st             = ST_STORED;
            r.stored_byte  = it.rx_byte;
            r.stored_index = 9'd1;
            phase          = (it.rx_byte == 8'd0) ? PH_CRCH : PH_DATA;
          end
          PH_DATA: begin
            crc            = crc_next(crc, it.rx_byte);
            st             = ST_STORED;
            r.stored_byte  = it.rx_byte;
            r.stored_index = 9'd2 + 9'(data_count);
            data_count     = data_count + 8'd1;
            if (data_count >= reply_len) phase = PH_CRCH;
          end
          PH_CRCH: begin
            crc_hi = it.rx_byte;
            phase  = PH_CRCL;
          end
          default: begin
            got   = {crc_hi, it.rx_byte};
            st    = (got == crc && reply_addr == master_addr) ? ST_OK : ST_BAD;
            phase = PH_IDLE;
          end
        endcase
      end else if (it.cmd == CMD_TICK) begin
        if (elapsed < ElapsedMax) elapsed = elapsed + 13'd1;
        if (elapsed >= limit) begin
          st    = ST_TIMEOUT;
          phase = PH_IDLE;
        end
      end
      r.status = st;
      pending.push_back(r);
      return st;
    endfunction

    function void check_beat(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d byte %02h index %0d",
                   got.status, got.stored_byte, got.stored_index);
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status || got.stored_byte !== exp_r.stored_byte ||
          got.stored_index !== exp_r.stored_index) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st %0d byte %02h idx %0d, got st %0d byte %02h idx %0d",
                   exp_r.status, exp_r.stored_byte, exp_r.stored_index,
                   got.status, got.stored_byte, got.stored_index);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] cmd = CMD_NONE;
  logic [7:0] rx_byte = '0;
  logic [7:0] tx_address = '0;
  logic [7:0] tx_length = '0;

  // output channel
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        status;
  logic [7:0]        stored_byte;
  logic [IndexW-1:0] stored_index;

  // config port
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  reply_scoreboard sb;
  int send_pct = 0;    // chance per cycle that the sender holds off
  int recv_pct = 0;    // chance per cycle that the receiver stalls
  int counted  = 0;    // beats the block acts on (not ignored while idle)

  always #2 clk = ~clk;

  crc_framed_reply_receiver_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .rx_byte_i      (rx_byte),
    .tx_address_i   (tx_address),
    .tx_length_i    (tx_length),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .stored_byte_o  (stored_byte),
    .stored_index_o (stored_index),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  // receiver side: random backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_pct);
  end

  // result monitor: a beat moves when valid and ready were both high before the edge
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status       = status;
      got.stored_byte  = stored_byte;
      got.stored_index = stored_index;
      sb.check_beat(got);
    end
  end

  // random filler for the fields the command does not use
  function automatic item_t make_item(cmd_e c, logic [7:0] b);
    item_t it;
    it.cmd        = c;
    it.rx_byte    = b;
    it.tx_address = 8'($urandom);
    it.tx_length  = 8'($urandom);
    return it;
  endfunction

  function automatic item_t make_start(logic [7:0] a, logic [7:0] l);
    item_t it;
    it            = make_item(CMD_START, 8'($urandom));
    it.tx_address = a;
    it.tx_length  = l;
    return it;
  endfunction

  // one input beat; valid stays up until accepted
  task automatic send_beat(input item_t it);
    status_e st;
    if (send_pct > 0) begin
      while ($urandom_range(99) < send_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    cmd        <= it.cmd;
    rx_byte    <= it.rx_byte;
    tx_address <= it.tx_address;
    tx_length  <= it.tx_length;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    st = sb.note_beat(it);
    if (st != ST_IDLE) counted++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(make_item(CMD_BYTE, b));
  endtask

  // tick only if it cannot end the wait, else an unused command
  task automatic send_filler();
    if (sb.elapsed + 13'd1 < sb.limit) send_beat(make_item(CMD_TICK, 8'($urandom)));
    else send_beat(make_item(CMD_NONE, 8'($urandom)));
  endtask

  // full reply frame: address, length, random data, crc high then low
  task automatic send_reply(input logic [7:0] addr, input logic [7:0] len,
                            input bit bad_crc, input bit noisy);
    logic [7:0]  frame[$];
    logic [15:0] c;
    frame.push_back(addr);
    frame.push_back(len);
    for (int k = 0; k < len; k++) frame.push_back(8'($urandom));
    c = CrcInit;
    foreach (frame[k]) c = reply_scoreboard::crc_next(c, frame[k]);
    if (bad_crc) c = c ^ (16'd1 << $urandom_range(15));
    frame.push_back(c[15:8]);
    frame.push_back(c[7:0]);
    foreach (frame[k]) begin
      if (noisy && $urandom_range(9) == 0) send_filler();
      send_byte(frame[k]);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected beat, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic directed_part();
    logic [7:0]  frame[$];
    logic [15:0] c;
    send_beat(make_start(BroadcastAddr, 8'hFF));     // broadcast succeeds at once
    send_byte(8'hFF);                                // ignored while idle
    send_beat(make_item(CMD_TICK, 8'h00));
    send_beat(make_item(CMD_NONE, 8'h00));
    send_beat(make_start(8'h00, 8'h00));
    send_reply(8'h00, 8'h00, 1'b0, 1'b0);            // zero length, good
    // wrong reply address with good crc, unused command and tick mid-frame
    send_beat(make_start(8'hFE, 8'hFF));
    frame = '{8'hFF, 8'h02, 8'h00, 8'hFF};
    c = CrcInit;
    foreach (frame[k]) c = reply_scoreboard::crc_next(c, frame[k]);
    send_byte(frame[0]);
    send_byte(frame[1]);
    send_beat(make_item(CMD_NONE, 8'hAA));
    send_beat(make_item(CMD_TICK, 8'h55));
    send_byte(frame[2]);
    send_byte(frame[3]);
    send_byte(c[15:8]);
    send_byte(c[7:0]);
    // start while receiving abandons the frame, then a bad crc
    send_beat(make_start(8'h01, 8'h01));
    send_byte(8'h00);
    send_beat(make_start(8'h02, 8'h03));
    send_reply(8'h00, 8'h01, 1'b1, 1'b0);
  endtask

  task automatic random_sequence();
    int          r;
    int          n;
    logic [7:0]  len;
    logic [7:0]  addr;
    r = $urandom_range(99);
    if (r < 55) begin
      send_beat(make_start(8'($urandom_range(254)), 8'($urandom)));
      addr = ($urandom_range(99) < 85) ? sb.master_addr : 8'($urandom);
      n = $urandom_range(99);
      if (n < 80) len = 8'($urandom_range(6));
      else if (n < 98) len = 8'($urandom_range(7, 40));
      else len = 8'hFF;
      if ($urandom_range(99) < 5) begin
        // abandoned reply, next start or idle noise follows
        send_byte(addr);
        repeat ($urandom_range(3)) send_byte(8'($urandom));
      end else begin
        send_reply(addr, len, $urandom_range(99) < 15, $urandom_range(1) == 1);
      end
    end else if (r < 67) begin
      // silence until the wait runs out or 300 ticks have been sent
      send_beat(make_start(8'($urandom_range(254)), 8'($urandom_range(10))));
      if ($urandom_range(99) < 70) send_byte(sb.master_addr);
      if ($urandom_range(99) < 30) send_byte(8'($urandom_range(8)));
      n = 0;
      while (sb.phase != PH_IDLE && n < 300) begin
        send_beat(make_item(CMD_TICK, 8'($urandom)));
        n++;
      end
    end else if (r < 74) begin
      send_beat(make_start(BroadcastAddr, 8'($urandom)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_beat(make_item(cmd_e'(2'($urandom_range(3))), 8'($urandom)));
      end
    end
  endtask

  initial begin
    logic [7:0] bases[8];
    logic [3:0] btimes[8];
    logic [7:0] masters[8];
    int         mode;
    sb = new();
    bases   = '{8'd25, 8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(1, 255)), 8'd10, 8'd200};
    btimes  = '{4'd2, 4'd0, 4'd15, 4'd0, 4'd1, 4'($urandom_range(15)), 4'd15, 4'd7};
    masters = '{8'h00, 8'hFF, 8'h5A, 8'h3C, 8'hA5, 8'($urandom), 8'hFF, 8'h00};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    drain();
    write_reg(CFG_UNUSED, 8'($urandom));
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_BASE_TIMEOUT, bases[p]);
      write_reg(CFG_PER_BYTE, 8'(btimes[p]));
      write_reg(CFG_MASTER_ADDR, masters[p]);
      // idling mode: none, sender, receiver, both
      mode = p % 4;
      send_pct = (mode == 1) ? 58 : (mode == 3) ? 36 : 0;
      recv_pct = (mode == 2) ? 58 : (mode == 3) ? 36 : 0;
      while (counted < 25 + (p + 1) * 85) random_sequence();
      drain();
    end
    send_pct = 0;
    recv_pct = 0;
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
